>>> hw/rtl/hws_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and register map of the wave-space Helmholtz scaler.
package hws_pkg;

    // Field widths
    localparam int SAMPLE_W  = 32;
    localparam int IDX_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int CNST_W    = 40;
    localparam int NORM_W    = 32;
    localparam int CNST_FRAC = 8;

    // Wave-number path: |g| stays below 2^IDX_W, so it fits a signed SIZE_W word
    localparam int WAVE_W = SIZE_W;
    localparam int SQ_W   = 2 * IDX_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int W_W    = CNST_W + 1;
    localparam int WMAG_W = CNST_W;

    // Scale path: q = c * n / (W * 2^(NORM_W - CNST_FRAC)), one extra bit kept for rounding
    localparam int PROD_W    = SAMPLE_W + NORM_W;
    localparam int X_LSB     = NORM_W - CNST_FRAC - 1;
    localparam int X_W       = PROD_W - 1 - X_LSB;
    localparam int QUOT_W    = X_W - CNST_FRAC;
    localparam int REM_W     = WMAG_W;
    localparam int DIV_STEPS = QUOT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CNST_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HELM_CNST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE = 3'd4;

    localparam logic [SIZE_W-1:0] RST_SIZE = 13'd64;
    localparam logic [CNST_W-1:0] RST_CNST = 40'd0;
    localparam logic [NORM_W-1:0] RST_NORM = 32'd16;

    // Saturation limits
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN_MAG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] coef_re;
        logic signed [SAMPLE_W-1:0] coef_im;
        logic        [IDX_W-1:0]    index_x;
        logic        [IDX_W-1:0]    index_y;
        logic        [IDX_W-1:0]    index_z;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_re;
        logic signed [SAMPLE_W-1:0] out_im;
        logic                       zeroed;
    } t_out_item;

    typedef struct packed {
        logic        [SIZE_W-1:0] size_x;
        logic        [SIZE_W-1:0] size_y;
        logic        [SIZE_W-1:0] size_z;
        logic signed [CNST_W-1:0] helmholtz_constant;
        logic        [NORM_W-1:0] norm_scale;
    } t_cfg;

    typedef struct packed {
        logic zero_w;
        logic neg_re;
        logic neg_im;
    } t_tag;

    typedef struct packed {
        logic [X_W-1:0]    x_re;
        logic [X_W-1:0]    x_im;
        logic [WMAG_W-1:0] wmag;
        t_tag              tag;
    } t_div_in;

    typedef struct packed {
        logic [QUOT_W-1:0] quot_re;
        logic [QUOT_W-1:0] quot_im;
        t_tag              tag;
    } t_div_out;

endpackage

>>> hw/rtl/hws_front.sv
`timescale 1ns / 1ps
// Front pipeline: index fold, squares, Helmholtz denominator and coefficient products.
module hws_front
    import hws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_div_in  o_data
);

    function automatic logic signed [WAVE_W-1:0] fold(input logic [IDX_W-1:0]  idx,
                                                      input logic [SIZE_W-1:0] size);
        logic signed [SIZE_W:0] i_s;
        logic signed [SIZE_W:0] d_s;
        i_s  = signed'({{(SIZE_W+1-IDX_W){1'b0}}, idx});
        d_s  = signed'({1'b0, size}) - i_s;
        fold = (i_s < d_s) ? i_s[WAVE_W-1:0] : d_s[WAVE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
        magnitude = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Stage 1: fold and coefficient magnitude
    logic                      r1_valid;
    logic signed [WAVE_W-1:0]  r1_gx, r1_gy, r1_gz;
    logic        [SAMPLE_W-1:0] r1_mag_re, r1_mag_im;
    logic                      r1_neg_re, r1_neg_im;

    // Stage 2: squares and products
    logic                      r2_valid;
    logic [SQ_W-1:0]           r2_sqx, r2_sqy, r2_sqz;
    logic [X_W-1:0]            r2_x_re, r2_x_im;
    logic                      r2_neg_re, r2_neg_im;

    // Stage 3: denominator
    logic                      r3_valid;
    logic signed [W_W-1:0]     r3_w;
    logic [X_W-1:0]            r3_x_re, r3_x_im;
    logic                      r3_neg_re, r3_neg_im;

    // Stage 4 is the output register
    logic                      r4_valid;
    t_div_in                   r4_data;

    logic signed [2*WAVE_W-1:0] sqx_full, sqy_full, sqz_full;
    logic [PROD_W-1:0]          prod_re, prod_im;
    logic [SUM_W-1:0]           sq_sum;
    logic signed [W_W-1:0]      n_w;
    logic [W_W-1:0]             w_abs;
    logic [WMAG_W-1:0]          n_wmag;

    always_comb begin
        sqx_full = r1_gx * r1_gx;
        sqy_full = r1_gy * r1_gy;
        sqz_full = r1_gz * r1_gz;
        prod_re  = r1_mag_re * i_cfg.norm_scale;
        prod_im  = r1_mag_im * i_cfg.norm_scale;
    end

    always_comb begin
        sq_sum = {2'b00, r2_sqx} + {2'b00, r2_sqy} + {2'b00, r2_sqz};
        n_w    = signed'({i_cfg.helmholtz_constant[CNST_W-1], i_cfg.helmholtz_constant})
               - signed'({{(W_W-SUM_W-CNST_FRAC){1'b0}}, sq_sum, {CNST_FRAC{1'b0}}});
    end

    always_comb begin
        w_abs  = r3_w[W_W-1] ? (~r3_w + 1'b1) : r3_w;
        n_wmag = w_abs[WMAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_gx     <= fold(i_item.index_x, i_cfg.size_x);
            r1_gy     <= fold(i_item.index_y, i_cfg.size_y);
            r1_gz     <= fold(i_item.index_z, i_cfg.size_z);
            r1_mag_re <= magnitude(i_item.coef_re);
            r1_mag_im <= magnitude(i_item.coef_im);
            r1_neg_re <= i_item.coef_re[SAMPLE_W-1];
            r1_neg_im <= i_item.coef_im[SAMPLE_W-1];

            r2_sqx    <= sqx_full[SQ_W-1:0];
            r2_sqy    <= sqy_full[SQ_W-1:0];
            r2_sqz    <= sqz_full[SQ_W-1:0];
            r2_x_re   <= prod_re[X_LSB +: X_W];
            r2_x_im   <= prod_im[X_LSB +: X_W];
            r2_neg_re <= r1_neg_re;
            r2_neg_im <= r1_neg_im;

            r3_w      <= n_w;
            r3_x_re   <= r2_x_re;
            r3_x_im   <= r2_x_im;
            r3_neg_re <= r2_neg_re;
            r3_neg_im <= r2_neg_im;

            r4_data.x_re       <= r3_x_re;
            r4_data.x_im       <= r3_x_im;
            r4_data.wmag       <= n_wmag;
            // |w| below one in Q.8: force the result to zero
            r4_data.tag.zero_w <= (n_wmag[WMAG_W-1:CNST_FRAC] == '0);
            r4_data.tag.neg_re <= r3_neg_re ^ r3_w[W_W-1];
            r4_data.tag.neg_im <= r3_neg_im ^ r3_w[W_W-1];
        end
    end

    assign o_valid = r4_valid;
    assign o_data  = r4_data;

endmodule

>>> hw/rtl/hws_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage for both parts of the coefficient.
module hws_div
    import hws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_valid,
    input  t_div_in  i_data,
    output logic     o_valid,
    output t_div_out o_data
);

    // One step: bring in the next dividend bit, subtract if it fits, shift in the quotient bit
    function automatic logic [REM_W+QUOT_W-1:0] div_step(input logic [REM_W-1:0]  rem,
                                                         input logic [QUOT_W-1:0] sh,
                                                         input logic [WMAG_W-1:0] dvs);
        logic [REM_W:0] rem_sh;
        logic [REM_W:0] diff;
        rem_sh = {rem, sh[QUOT_W-1]};
        diff   = rem_sh - {1'b0, dvs};
        if (rem_sh >= {1'b0, dvs}) begin
            div_step = {diff[REM_W-1:0], sh[QUOT_W-2:0], 1'b1};
        end else begin
            div_step = {rem_sh[REM_W-1:0], sh[QUOT_W-2:0], 1'b0};
        end
    endfunction

    // Stage inputs; entry 0 comes from the front, entry k+1 from stage k
    logic              stg_valid   [0:DIV_STEPS];
    logic [REM_W-1:0]  stg_rem_re  [0:DIV_STEPS];
    logic [REM_W-1:0]  stg_rem_im  [0:DIV_STEPS];
    logic [QUOT_W-1:0] stg_sh_re   [0:DIV_STEPS];
    logic [QUOT_W-1:0] stg_sh_im   [0:DIV_STEPS];
    logic [WMAG_W-1:0] stg_wmag    [0:DIV_STEPS];
    t_tag              stg_tag     [0:DIV_STEPS];

    logic              r_valid     [0:DIV_STEPS-1];
    logic [REM_W-1:0]  r_rem_re    [0:DIV_STEPS-1];
    logic [REM_W-1:0]  r_rem_im    [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] r_sh_re     [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] r_sh_im     [0:DIV_STEPS-1];
    logic [WMAG_W-1:0] r_wmag      [0:DIV_STEPS-1];
    t_tag              r_tag       [0:DIV_STEPS-1];

    logic [REM_W-1:0]  n_rem_re    [0:DIV_STEPS-1];
    logic [REM_W-1:0]  n_rem_im    [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] n_sh_re     [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] n_sh_im     [0:DIV_STEPS-1];

    // The top dividend bits are below the divisor, so they seed the remainder directly
    assign stg_valid[0]  = i_valid;
    assign stg_rem_re[0] = {{(REM_W-X_W+QUOT_W){1'b0}}, i_data.x_re[X_W-1:QUOT_W]};
    assign stg_rem_im[0] = {{(REM_W-X_W+QUOT_W){1'b0}}, i_data.x_im[X_W-1:QUOT_W]};
    assign stg_sh_re[0]  = i_data.x_re[QUOT_W-1:0];
    assign stg_sh_im[0]  = i_data.x_im[QUOT_W-1:0];
    assign stg_wmag[0]   = i_data.wmag;
    assign stg_tag[0]    = i_data.tag;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        always_comb begin
            {n_rem_re[k], n_sh_re[k]} = div_step(stg_rem_re[k], stg_sh_re[k], stg_wmag[k]);
            {n_rem_im[k], n_sh_im[k]} = div_step(stg_rem_im[k], stg_sh_im[k], stg_wmag[k]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= stg_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem_re[k] <= n_rem_re[k];
                r_rem_im[k] <= n_rem_im[k];
                r_sh_re[k]  <= n_sh_re[k];
                r_sh_im[k]  <= n_sh_im[k];
                r_wmag[k]   <= stg_wmag[k];
                r_tag[k]    <= stg_tag[k];
            end
        end

        assign stg_valid[k+1]  = r_valid[k];
        assign stg_rem_re[k+1] = r_rem_re[k];
        assign stg_rem_im[k+1] = r_rem_im[k];
        assign stg_sh_re[k+1]  = r_sh_re[k];
        assign stg_sh_im[k+1]  = r_sh_im[k];
        assign stg_wmag[k+1]   = r_wmag[k];
        assign stg_tag[k+1]    = r_tag[k];
    end

    // After the last step the shift register holds the whole quotient
    assign o_valid        = stg_valid[DIV_STEPS];
    assign o_data.quot_re = stg_sh_re[DIV_STEPS];
    assign o_data.quot_im = stg_sh_im[DIV_STEPS];
    assign o_data.tag     = stg_tag[DIV_STEPS];

endmodule

>>> hw/rtl/hws_round.sv
`timescale 1ns / 1ps
// Output stage: round half away from zero, apply sign, saturate and hold the result item.
module hws_round
    import hws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_div_out  i_data,
    output logic      o_valid,
    output t_out_item o_item
);

    // Quotient carries one extra fraction bit; round on it
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic [QUOT_W-1:0] quot,
                                                      input logic              neg);
        logic [QUOT_W-1:0] q;
        q = {1'b0, quot[QUOT_W-1:1]} + {{(QUOT_W-1){1'b0}}, quot[0]};
        if (neg) begin
            if (q > SAMPLE_MIN_MAG) begin
                round_sat = SAMPLE_MIN_MAG;
            end else begin
                round_sat = ~q + 1'b1;
            end
        end else if (q > SAMPLE_MAX) begin
            round_sat = SAMPLE_MAX;
        end else begin
            round_sat = q;
        end
    endfunction

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        n_item.zeroed = i_data.tag.zero_w;
        if (i_data.tag.zero_w) begin
            n_item.out_re = '0;
            n_item.out_im = '0;
        end else begin
            n_item.out_re = round_sat(i_data.quot_re, i_data.tag.neg_re);
            n_item.out_im = round_sat(i_data.quot_im, i_data.tag.neg_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> hw/rtl/helmholtz_wavespace_scale.sv
`timescale 1ns / 1ps
// Top level of the wave-space Helmholtz scaler: configuration registers, flow control, pipeline.
//
//  Channel   Direction  Handshake                    Payload
//  in        into       i_in_valid / o_in_stall      i_in_item  (t_in_item)
//  out       out of     o_out_valid / i_out_stall    o_out_item (t_out_item)
//  cfg       into       i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  One item enters per cycle while o_in_stall is low; each result passes through the
//  4 front stages (fold, square/multiply, denominator, magnitude), 32 divider stages
//  (one quotient bit each) and the rounding/output register.
//  Reset is synchronous, active low; it empties the pipeline and loads the register defaults.
//  A stalled result holds the whole pipeline, and o_in_stall rises in the same cycle.
module helmholtz_wavespace_scale
    import hws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [CNST_W-1:0] r_cnst;
    logic [NORM_W-1:0] r_norm;

    t_cfg     cfg;
    logic     adv;
    logic     in_take;
    logic     front_valid;
    t_div_in  front_data;
    logic     div_valid;
    t_div_out div_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= RST_SIZE;
            r_size_y <= RST_SIZE;
            r_size_z <= RST_SIZE;
            r_cnst   <= RST_CNST;
            r_norm   <= RST_NORM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X:     r_size_x <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:     r_size_y <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:     r_size_z <= i_cfg_data[SIZE_W-1:0];
                CFG_HELM_CNST:  r_cnst   <= i_cfg_data[CNST_W-1:0];
                CFG_NORM_SCALE: r_norm   <= i_cfg_data[NORM_W-1:0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    always_comb begin
        cfg.size_x             = r_size_x;
        cfg.size_y             = r_size_y;
        cfg.size_z             = r_size_z;
        cfg.helmholtz_constant = signed'(r_cnst);
        cfg.norm_scale         = r_norm;
    end

    // Advance everything unless a finished result is waiting on the output
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign in_take    = i_in_valid && adv;

    hws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (cfg),
        .i_valid (in_take),
        .i_item  (i_in_item),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    hws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    hws_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_valid),
        .i_data  (div_data),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule
